>>> rtl/led_frame_remap_dim_gamma_assert.svh
// Assertion macros shared by the LED frame remap, dim and gamma RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef LED_FRAME_REMAP_DIM_GAMMA_ASSERT_SVH
`define LED_FRAME_REMAP_DIM_GAMMA_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define LFRDG_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define LFRDG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lfrdg_pkg.sv
// Types and constants for the LED frame remap, dim and gamma block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lfrdg_pkg;

    localparam int ADDR_W      = 9;
    localparam int DATA_W      = 8;
    localparam int MAP_DATA_W  = 7;
    localparam int LED_W       = 8;
    localparam int CH_W        = 2;
    localparam int GAMMA_DEPTH = 256;
    localparam int CFG_AW      = 4;
    localparam int CFG_DW      = 32;
    localparam int DIM_W       = 9;
    localparam int BOOST_K_W   = 13;
    localparam int PROD1_W     = 16;
    localparam int PROD2_W     = 21;
    localparam int RECIP_W     = 21;
    localparam int RECIP_PW    = PROD2_W + RECIP_W;
    localparam int RECIP_SHIFT = 33;
    localparam int Q2_W        = RECIP_PW - RECIP_SHIFT;

    // floor(n / 5100) == (n * RECIP_5100) >> 33 for every n below 2**21
    localparam logic [RECIP_W-1:0]   RECIP_5100  = 21'd1684301;
    localparam logic [PROD2_W-1:0]   BOOST_LIMIT = 21'd1300500;
    localparam logic [DATA_W-1:0]    DIM_CLAMP   = 8'd254;
    localparam logic [DIM_W-1:0]     DIM_MAX     = 9'd255;
    localparam logic [BOOST_K_W-1:0] BOOST_MUL   = 13'd20;
    localparam logic [BOOST_K_W-1:0] BOOST_ADD   = 13'd255;

    localparam logic [LED_W-1:0] WEAK_LED_A = 8'd14;
    localparam logic [LED_W-1:0] WEAK_LED_B = 8'd77;
    localparam logic [LED_W-1:0] WEAK_LED_C = 8'd78;
    localparam logic [LED_W-1:0] WEAK_LED_D = 8'd81;

    // multiply by 171 then shift by 9 gives address / 3 for address below 512
    localparam logic [LED_W-1:0] DIV3_MUL   = 8'd171;
    localparam int               DIV3_SHIFT = 9;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PW    = 2;
    localparam int QUEUE_CW    = 3;

    typedef enum logic [1:0] {
        OP_FRAME  = 2'd0,
        OP_MAP    = 2'd1,
        OP_GAMMA  = 2'd2,
        OP_RENDER = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_DIM_LEVEL    = 2'd0,
        REG_BLANK_FRAME  = 2'd1,
        REG_BOOST_ENABLE = 2'd2,
        REG_DIM_MODE     = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0]    dim;
        logic [BOOST_K_W-1:0] boost_k;
        logic                 blank;
        logic                 boost_on;
    } cfg_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [LED_W-1:0]  led;
        logic [CH_W-1:0]   ch;
        logic              weak_led;
    } item_t;

endpackage

`default_nettype wire

>>> rtl/led_frame_remap_dim_gamma.sv
// Top level of the LED frame remap, dim and gamma output stage.
// Depends on lfrdg_pkg, lfrdg_cfg, lfrdg_front, lfrdg_queue and lfrdg_back.
//
//   Channel   Direction  Handshake             Payload
//   ------------------------------------------------------------------------
//   config    in/out     psel/penable/pready   paddr, pwdata, prdata
//   input     in         in_valid/in_ready     operation, address, data
//   output    out        out_valid/out_ready   out_byte, out_index
//
// One beat per cycle sustained in both directions while out_ready is held; a render
// beat passes from the front register through the queue, map, frame, two scaling
// stages and the gamma/output register. Writes give no output beat.
// Reset clears control state only; the frame, map and gamma stores hold
// nothing until written and get no clearing pass.
// An output stall freezes the back pipeline; the four-entry queue keeps the
// input side taking beats until it fills.
`timescale 1ns / 1ps
`default_nettype none

module led_frame_remap_dim_gamma
    import lfrdg_pkg::*;
#(
    parameter int NUM_LEDS = 128
)
(
    input  wire  logic              clk,
    input  wire  logic              rst_n,
    input  wire  logic              psel,
    input  wire  logic              penable,
    input  wire  logic              pwrite,
    input  wire  logic [CFG_AW-1:0] paddr,
    input  wire  logic [CFG_DW-1:0] pwdata,
    output logic       [CFG_DW-1:0] prdata,
    output logic                    pready,
    input  wire  logic              in_valid,
    output logic                    in_ready,
    input  wire  logic [1:0]        operation,
    input  wire  logic [ADDR_W-1:0] address,
    input  wire  logic [DATA_W-1:0] data,
    output logic                    out_valid,
    input  wire  logic              out_ready,
    output logic       [DATA_W-1:0] out_byte,
    output logic       [ADDR_W-1:0] out_index
);

    cfg_t  cfg;
    logic  push;
    item_t push_item;
    logic  queue_full;
    logic  pop;
    logic  q_not_empty;
    item_t q_head;

    // Register file; derived dim, boost factor and flags are registered again from the written registers.
    lfrdg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Accept, drop out-of-range items, split render address into LED and channel.
    lfrdg_front #(
        .NUM_LEDS (NUM_LEDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .address    (address),
        .data       (data),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    // Decouple the front from back-end stalls.
    lfrdg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // Store writes and renders in order through the table pipeline.
    lfrdg_back #(
        .NUM_LEDS (NUM_LEDS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .out_index   (out_index)
    );

endmodule

`default_nettype wire

>>> rtl/lfrdg_cfg.sv
// Configuration register file with an APB-style slave port.
// Depends on lfrdg_pkg; publishes the derived scaling settings as cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module lfrdg_cfg
    import lfrdg_pkg::*;
(
    input  wire  logic              clk,
    input  wire  logic              rst_n,
    input  wire  logic              psel,
    input  wire  logic              penable,
    input  wire  logic              pwrite,
    input  wire  logic [CFG_AW-1:0] paddr,
    input  wire  logic [CFG_DW-1:0] pwdata,
    output logic       [CFG_DW-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    logic [DIM_W-1:0] dim_level_reg;
    logic             blank_frame_reg;
    logic             boost_enable_reg;
    logic             dim_mode_reg;
    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic             wr_en;
    cfg_idx_t         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = cfg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_level_reg    <= DIM_MAX;
            blank_frame_reg  <= 1'b0;
            boost_enable_reg <= 1'b0;
            dim_mode_reg     <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_DIM_LEVEL:    dim_level_reg    <= pwdata[DIM_W-1:0];
                REG_BLANK_FRAME:  blank_frame_reg  <= pwdata[0];
                REG_BOOST_ENABLE: boost_enable_reg <= pwdata[0];
                REG_DIM_MODE:     dim_mode_reg     <= pwdata[0];
                default:          dim_mode_reg     <= dim_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_DIM_LEVEL:    prdata = CFG_DW'(dim_level_reg);
            REG_BLANK_FRAME:  prdata = CFG_DW'(blank_frame_reg);
            REG_BOOST_ENABLE: prdata = CFG_DW'(boost_enable_reg);
            REG_DIM_MODE:     prdata = CFG_DW'(dim_mode_reg);
            default:          prdata = '0;
        endcase
    end

    // Clamp the level and precompute the boost factor 20*d + 255.
    always_comb
    begin
        cfg_next.dim      = (dim_level_reg > DIM_MAX) ? DIM_CLAMP : dim_level_reg[DATA_W-1:0];
        cfg_next.boost_k  = BOOST_K_W'(cfg_next.dim) * BOOST_MUL + BOOST_ADD;
        cfg_next.blank    = blank_frame_reg;
        cfg_next.boost_on = boost_enable_reg && dim_mode_reg && (dim_level_reg != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dim      <= DIM_MAX[DATA_W-1:0];
            cfg_reg.boost_k  <= BOOST_K_W'(DIM_MAX) * BOOST_MUL + BOOST_ADD;
            cfg_reg.blank    <= 1'b0;
            cfg_reg.boost_on <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/lfrdg_front.sv
// Front end: accepts input beats, drops out-of-range items and classifies renders.
// Depends on lfrdg_pkg; feeds lfrdg_queue.
`timescale 1ns / 1ps
`default_nettype none

module lfrdg_front
    import lfrdg_pkg::*;
#(
    parameter int NUM_LEDS = 128
)
(
    input  wire  logic              clk,
    input  wire  logic              rst_n,
    input  wire  logic              in_valid,
    output logic                    in_ready,
    input  wire  logic [1:0]        operation,
    input  wire  logic [ADDR_W-1:0] address,
    input  wire  logic [DATA_W-1:0] data,
    output logic                    push,
    output item_t                   push_item,
    input  wire  logic              queue_full
);

    localparam logic [31:0] FRAME_BYTES = 32'(3 * NUM_LEDS);
    localparam logic [31:0] MAP_DEPTH   = 32'(NUM_LEDS);

    logic                       f_valid_reg;
    item_t                      f_item_reg;
    item_t                      f_item_next;
    logic                       keep;
    logic                       accept;
    logic [ADDR_W+LED_W-1:0]    div_prod;
    logic [ADDR_W:0]            rem_wide;
    logic [CH_W-1:0]            rem;
    logic [31:0]                addr32;

    assign in_ready = !f_valid_reg || !queue_full;
    assign accept   = in_valid && in_ready;
    assign push     = f_valid_reg && !queue_full;
    assign push_item = f_item_reg;
    assign addr32   = 32'(address);

    // LED index and colour position; swap the first two channels for GRB.
    always_comb
    begin
        div_prod          = (ADDR_W+LED_W)'(address) * (ADDR_W+LED_W)'(DIV3_MUL);
        f_item_next.op    = op_t'(operation);
        f_item_next.addr  = address;
        f_item_next.data  = data;
        f_item_next.led   = div_prod[DIV3_SHIFT +: LED_W];
        rem_wide          = {1'b0, address} - ((ADDR_W+1)'(f_item_next.led) * (ADDR_W+1)'(3));
        rem               = rem_wide[CH_W-1:0];
        case (rem)
            2'd0:    f_item_next.ch = 2'd1;
            2'd1:    f_item_next.ch = 2'd0;
            default: f_item_next.ch = 2'd2;
        endcase
        f_item_next.weak_led = (f_item_next.led == WEAK_LED_A) ||
                               (f_item_next.led == WEAK_LED_B) ||
                               (f_item_next.led == WEAK_LED_C) ||
                               (f_item_next.led == WEAK_LED_D);
    end

    // Drop writes and renders outside their stores here.
    always_comb
    begin
        unique case (op_t'(operation))
            OP_FRAME:  keep = addr32 < FRAME_BYTES;
            OP_MAP:    keep = addr32 < MAP_DEPTH;
            OP_GAMMA:  keep = addr32 < 32'(GAMMA_DEPTH);
            OP_RENDER: keep = addr32 < FRAME_BYTES;
            default:   keep = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            f_valid_reg <= keep;
        end
        else if (push)
        begin
            f_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_item_reg <= f_item_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/lfrdg_queue.sv
// Short FIFO between the front end and the back-end pipeline.
// Depends on lfrdg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "led_frame_remap_dim_gamma_assert.svh"

module lfrdg_queue
    import lfrdg_pkg::*;
(
    input  wire  logic  clk,
    input  wire  logic  rst_n,
    input  wire  logic  push,
    input  wire  item_t push_item,
    output logic        full,
    input  wire  logic  pop,
    output logic        not_empty,
    output item_t       head
);

    item_t                storage_reg [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0]  wr_ptr_reg;
    logic [QUEUE_PW-1:0]  rd_ptr_reg;
    logic [QUEUE_CW-1:0]  count_reg;
    logic [QUEUE_CW-1:0]  count_next;

    assign full      = count_reg == QUEUE_CW'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = storage_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            storage_reg[wr_ptr_reg] <= push_item;
        end
    end

    `LFRDG_ASSERT_ALWAYS(a_queue_bound, count_reg <= QUEUE_CW'(QUEUE_DEPTH), "queue overfilled")

endmodule

`default_nettype wire

>>> rtl/lfrdg_back.sv
// Back-end pipeline: map lookup, frame fetch, scaling, gamma lookup, output register.
// Depends on lfrdg_pkg and the assertion macro header; holds the three stores.
`timescale 1ns / 1ps
`default_nettype none
`include "led_frame_remap_dim_gamma_assert.svh"

module lfrdg_back
    import lfrdg_pkg::*;
#(
    parameter int NUM_LEDS = 128
)
(
    input  wire  logic              clk,
    input  wire  logic              rst_n,
    input  wire  cfg_t              cfg,
    input  wire  logic              q_not_empty,
    input  wire  item_t             q_head,
    output logic                    pop,
    output logic                    out_valid,
    input  wire  logic              out_ready,
    output logic       [DATA_W-1:0] out_byte,
    output logic       [ADDR_W-1:0] out_index
);

    localparam int          FRAME_DEPTH = 3 * NUM_LEDS;
    localparam int          FRAME_AW    = $clog2(FRAME_DEPTH);
    localparam int          MAP_AW      = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam logic [31:0] FRAME_BYTES = 32'(FRAME_DEPTH);

    logic [MAP_DATA_W-1:0] map_mem   [NUM_LEDS];
    logic [DATA_W-1:0]     frame_mem [FRAME_DEPTH];
    logic [DATA_W-1:0]     gamma_mem [GAMMA_DEPTH];

    logic adv;

    logic                  s1_valid_reg;
    item_t                 s1_item_reg;
    logic [MAP_DATA_W-1:0] map_rd_reg;

    logic                  s2_valid_reg;
    item_t                 s2_item_reg;
    logic                  s2_src_ok_reg;
    logic [DATA_W-1:0]     frame_rd_reg;

    logic                  s3_valid_reg;
    item_t                 s3_item_reg;
    logic [PROD1_W-1:0]    s3_n1_reg;
    logic [PROD2_W-1:0]    s3_n2_reg;

    logic                  s4_valid_reg;
    item_t                 s4_item_reg;
    logic [DATA_W-1:0]     s4_q1_reg;
    logic [Q2_W-1:0]       s4_q2_reg;
    logic                  s4_lt_reg;

    logic                  out_valid_reg;
    logic [ADDR_W-1:0]     out_index_reg;
    logic [DATA_W-1:0]     gamma_rd_reg;

    logic [ADDR_W-1:0]     src;
    logic                  src_ok;
    logic [DATA_W-1:0]     pix;
    logic [PROD1_W-1:0]    div255_sum;
    logic [RECIP_PW-1:0]   recip_prod;
    logic [DATA_W-1:0]     level;

    // Whole pipeline advances while the output slot is free or being taken.
    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && q_not_empty;

    assign out_valid = out_valid_reg;
    assign out_byte  = gamma_rd_reg;
    assign out_index = out_index_reg;

    // Stage 2 source byte: mapped pixel times three plus channel.
    assign src    = ADDR_W'(map_rd_reg) * ADDR_W'(3) + ADDR_W'(s1_item_reg.ch);
    assign src_ok = 32'(src) < FRAME_BYTES;

    // Stage 3 input byte; outside the frame reads as zero.
    assign pix = s2_src_ok_reg ? frame_rd_reg : '0;

    // Stage 4: floor(n/255) for n up to 255*255, and reciprocal product for /5100.
    assign div255_sum = s3_n1_reg + PROD1_W'(s3_n1_reg[PROD1_W-1:DATA_W]) + PROD1_W'(1);
    assign recip_prod = RECIP_PW'(s3_n2_reg) * RECIP_PW'(RECIP_5100);

    // Stage 5: pick boosted or normal level, then blank.
    always_comb
    begin
        if (cfg.boost_on && s4_item_reg.weak_led && s4_lt_reg)
        begin
            level = s4_q2_reg[DATA_W-1:0];
        end
        else
        begin
            level = s4_q1_reg;
        end
        if (cfg.blank)
        begin
            level = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= q_not_empty;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg && (s4_item_reg.op == OP_RENDER);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg   <= q_head;
            s2_item_reg   <= s1_item_reg;
            s2_src_ok_reg <= src_ok;
            s3_item_reg   <= s2_item_reg;
            s3_n1_reg     <= PROD1_W'(pix) * PROD1_W'(cfg.dim);
            s3_n2_reg     <= PROD2_W'(pix) * PROD2_W'(cfg.boost_k);
            s4_item_reg   <= s3_item_reg;
            s4_q1_reg     <= div255_sum[PROD1_W-1:DATA_W];
            s4_q2_reg     <= recip_prod[RECIP_PW-1:RECIP_SHIFT];
            s4_lt_reg     <= s3_n2_reg < BOOST_LIMIT;
            out_index_reg <= s4_item_reg.addr;
        end
    end

    // Pixel map: written and read in stage 1.
    always_ff @(posedge clk)
    begin
        if (adv && q_not_empty)
        begin
            if (q_head.op == OP_MAP)
            begin
                map_mem[MAP_AW'(q_head.addr)] <= q_head.data[MAP_DATA_W-1:0];
            end
            else if (q_head.op == OP_RENDER)
            begin
                map_rd_reg <= map_mem[MAP_AW'(q_head.led)];
            end
        end
    end

    // Frame store: written and read in stage 2.
    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            if (s1_item_reg.op == OP_FRAME)
            begin
                frame_mem[FRAME_AW'(s1_item_reg.addr)] <= s1_item_reg.data;
            end
            else if ((s1_item_reg.op == OP_RENDER) && src_ok)
            begin
                frame_rd_reg <= frame_mem[FRAME_AW'(src)];
            end
        end
    end

    // Gamma table: written and read in stage 5, feeding the output register.
    always_ff @(posedge clk)
    begin
        if (adv && s4_valid_reg)
        begin
            if (s4_item_reg.op == OP_GAMMA)
            begin
                gamma_mem[s4_item_reg.addr[DATA_W-1:0]] <= s4_item_reg.data;
            end
            else if (s4_item_reg.op == OP_RENDER)
            begin
                gamma_rd_reg <= gamma_mem[level];
            end
        end
    end

    `LFRDG_ASSERT_NEXT(a_stall_freezes, !adv, $stable(s1_valid_reg) && $stable(s4_valid_reg), "pipeline moved during stall")
    `LFRDG_ASSERT_NEXT(a_render_out, adv && s4_valid_reg && (s4_item_reg.op == OP_RENDER), out_valid_reg && (out_index_reg == $past(s4_item_reg.addr)), "render lost at output")
    `LFRDG_ASSERT_ALWAYS(a_boost_range, !(s4_valid_reg && (s4_item_reg.op == OP_RENDER) && s4_lt_reg) || !s4_q2_reg[Q2_W-1], "boosted level out of range")

endmodule

`default_nettype wire

>>> bench/led_frame_remap_dim_gamma_test.sv
// Self-checking bench for the LED frame remap, dim and gamma output stage.
// Depends on lfrdg_pkg and the led_frame_remap_dim_gamma RTL; needs no files.
`timescale 1ns / 1ps

module led_frame_remap_dim_gamma_test;
    import lfrdg_pkg::*;

    localparam int LED_COUNT   = 128;
    localparam int FRAME_BYTES = 3 * LED_COUNT;
    localparam int GAMMA_SIZE  = 256;
    localparam int BOOST_DIV   = 5100;
    localparam int PHASE_BEATS = 86;

    // One beat on the command channel
    typedef struct {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] value;
    } led_cmd_t;

    // One beat on the LED chain side
    typedef struct {
        logic [DATA_W-1:0] level;
        logic [ADDR_W-1:0] index;
    } chain_byte_t;

    typedef struct {
        int unsigned dim;
        bit          blank;
        bit          boost;
        bit          dmode;
    } setting_t;

    // Register settings visited after the reset state, extremes included
    setting_t settings [9] = '{
        '{254, 1'b0, 1'b1, 1'b1},
        '{0,   1'b0, 1'b0, 1'b0},
        '{511, 1'b0, 1'b1, 1'b1},
        '{128, 1'b0, 1'b1, 1'b1},
        '{0,   1'b0, 1'b1, 1'b1},
        '{256, 1'b0, 1'b1, 1'b0},
        '{200, 1'b1, 1'b1, 1'b1},
        '{1,   1'b0, 1'b1, 1'b1},
        '{300, 1'b0, 1'b0, 1'b1}
    };

    int unsigned weak_leds [4] = '{14, 77, 78, 81};

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [CFG_AW-1:0]   paddr     = '0;
    logic [CFG_DW-1:0]   pwdata    = '0;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [1:0]          operation = OP_FRAME;
    logic [ADDR_W-1:0]   address   = '0;
    logic [DATA_W-1:0]   data      = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [DATA_W-1:0]   out_byte;
    logic [ADDR_W-1:0]   out_index;

    // Commands waiting for the driver, and chain bytes waiting for the DUT
    led_cmd_t    led_cmds  [$];
    chain_byte_t due_bytes [$];

    // Private copy of the stores and registers, updated as beats are taken
    logic [DATA_W-1:0]     frame_shadow [FRAME_BYTES];
    logic [MAP_DATA_W-1:0] map_shadow   [LED_COUNT];
    logic [DATA_W-1:0]     gamma_shadow [GAMMA_SIZE];
    logic [DIM_W-1:0]      dim_setting = 9'd255;
    bit                    blank_on    = 1'b0;
    bit                    boost_on    = 1'b0;
    bit                    dim_mode_on = 1'b0;

    // Handshake flags sampled at the rising edge, read by the falling-edge drivers
    bit in_fire  = 1'b0;
    bit out_fire = 1'b0;

    int beats_queued  = 0;
    int beats_taken   = 0;
    int bytes_checked = 0;
    int boosted_bytes = 0;
    int settings_done = 0;
    int fails         = 0;

    int  send_gap    = 0;
    bit  send_steady = 1'b0;
    int  take_stall  = 0;
    bit  take_steady = 1'b0;

    led_frame_remap_dim_gamma #(
        .NUM_LEDS (LED_COUNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .address   (address),
        .data      (data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_index (out_index)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the chain byte for an accepted beat, or update the stores.
    // Writes outside a store are dropped; renders past the frame give nothing.
    task automatic model_beat(input op_t op, input logic [ADDR_W-1:0] a,
                              input logic [DATA_W-1:0] v);
        int unsigned led;
        int unsigned chan;
        int unsigned src;
        int unsigned raw;
        int unsigned d;
        int unsigned num;
        int unsigned lvl;
        bit          weak_hit;
        chain_byte_t res;
        case (op)
            OP_FRAME:
                if (a < FRAME_BYTES)
                    frame_shadow[a] = v;
            OP_MAP:
                if (a < LED_COUNT)
                    map_shadow[a] = v[MAP_DATA_W-1:0];
            OP_GAMMA:
                if (a < GAMMA_SIZE)
                    gamma_shadow[a] = v;
            default:
                if (a < FRAME_BYTES)
                begin
                    led = a / 3;
                    // frame holds RGB, the chain wants GRB: swap the first two
                    case (a % 3)
                        0:       chan = 1;
                        1:       chan = 0;
                        default: chan = 2;
                    endcase
                    src = int'(map_shadow[led]) * 3 + chan;
                    raw = (src < FRAME_BYTES) ? int'(frame_shadow[src]) : 0;
                    d   = (dim_setting > 9'd255) ? 254 : int'(dim_setting);
                    lvl = (raw * d) / 255;
                    weak_hit = 1'b0;
                    foreach (weak_leds[i])
                        if (weak_leds[i] == led)
                            weak_hit = 1'b1;
                    // weak LEDs get d/255 + 0.05, held back where it would saturate
                    if (weak_hit && boost_on && dim_mode_on && dim_setting != 0)
                    begin
                        num = raw * (20 * d + 255);
                        if (num < 255 * BOOST_DIV)
                        begin
                            lvl = num / BOOST_DIV;
                            boosted_bytes++;
                        end
                    end
                    if (blank_on)
                        lvl = 0;
                    res.level = gamma_shadow[lvl[7:0]];
                    res.index = a;
                    due_bytes.push_back(res);
                end
        endcase
    endtask

    // Monitor: sample both channels and the register port at the rising edge
    always @(posedge clk)
    begin : watch
        chain_byte_t want;
        in_fire  = rst_n && in_valid && in_ready;
        out_fire = rst_n && out_valid && out_ready;
        if (rst_n && psel && penable && pwrite && pready)
        begin
            case (cfg_idx_t'(paddr[CFG_AW-1:2]))
                REG_DIM_LEVEL:    dim_setting = pwdata[DIM_W-1:0];
                REG_BLANK_FRAME:  blank_on    = pwdata[0];
                REG_BOOST_ENABLE: boost_on    = pwdata[0];
                REG_DIM_MODE:     dim_mode_on = pwdata[0];
                default: ;
            endcase
        end
        if (in_fire)
        begin
            model_beat(op_t'(operation), address, data);
            beats_taken++;
        end
        if (out_fire)
        begin
            if (due_bytes.size() == 0)
            begin
                $error("unexpected beat: out_byte %0d out_index %0d", out_byte, out_index);
                fails++;
            end
            else
            begin
                want = due_bytes.pop_front();
                bytes_checked++;
                if (out_byte !== want.level)
                begin
                    $error("out_byte: expected %0d, got %0d", want.level, out_byte);
                    fails++;
                end
                if (out_index !== want.index)
                begin
                    $error("out_index: expected %0d, got %0d", want.index, out_index);
                    fails++;
                end
            end
        end
    end

    // Driver: hold the beat until taken, then idle for the drawn gap and
    // present the next command. Steady stretches send back to back.
    always @(negedge clk)
    begin : feed
        led_cmd_t cmd;
        logic     next_valid;
        next_valid = in_valid && !in_fire;
        if (rst_n && !next_valid)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (led_cmds.size() > 0)
            begin
                cmd = led_cmds.pop_front();
                operation  <= cmd.op;
                address    <= cmd.addr;
                data       <= cmd.value;
                next_valid = 1'b1;
                if ($urandom_range(0, 29) == 0)
                    send_steady = !send_steady;
                send_gap = send_steady ? 0 : $urandom_range(0, 14);
            end
        end
        in_valid <= next_valid;
    end

    // Receiver: after each beat, stall for a drawn number of cycles
    always @(negedge clk)
    begin : sink
        if (out_fire)
        begin
            if ($urandom_range(0, 29) == 0)
                take_steady = !take_steady;
            take_stall = take_steady ? 0 : $urandom_range(0, 14);
        end
        if (take_stall > 0)
        begin
            take_stall--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic queue_cmd(input op_t op, input int unsigned a, input int unsigned v);
        led_cmd_t cmd;
        cmd.op    = op;
        cmd.addr  = a[ADDR_W-1:0];
        cmd.value = v[DATA_W-1:0];
        led_cmds.push_back(cmd);
        beats_queued++;
    endtask

    // Block until every queued beat is taken and every chain byte has come
    task automatic wait_idle();
        while (beats_taken != beats_queued || due_bytes.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drain the block, let trailing writes settle, then write all registers
    task automatic apply_setting(input setting_t s);
        wait_idle();
        repeat (16) @(negedge clk);
        write_reg(REG_DIM_LEVEL, CFG_DW'(s.dim));
        write_reg(REG_BLANK_FRAME, CFG_DW'(s.blank));
        write_reg(REG_BOOST_ENABLE, CFG_DW'(s.boost));
        write_reg(REG_DIM_MODE, CFG_DW'(s.dmode));
        settings_done++;
    endtask

    // Mostly in-range writes and renders; a tenth is noise past each store
    task automatic random_cmds(input int n);
        int unsigned pick;
        int unsigned a;
        op_t         op;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                if ($urandom_range(0, 3) == 0)
                    a = weak_leds[$urandom_range(0, 3)] * 3 + $urandom_range(0, 2);
                else
                    a = $urandom_range(0, FRAME_BYTES - 1);
                queue_cmd(OP_RENDER, a, $urandom_range(0, 255));
            end
            else if (pick < 70)
                queue_cmd(OP_FRAME, $urandom_range(0, FRAME_BYTES - 1), $urandom_range(0, 255));
            else if (pick < 80)
                queue_cmd(OP_MAP, $urandom_range(0, LED_COUNT - 1), $urandom_range(0, 255));
            else if (pick < 90)
                queue_cmd(OP_GAMMA, $urandom_range(0, GAMMA_SIZE - 1), $urandom_range(0, 255));
            else
            begin
                op = op_t'($urandom_range(0, 3));
                case (op)
                    OP_MAP:   a = $urandom_range(LED_COUNT, 511);
                    OP_GAMMA: a = $urandom_range(GAMMA_SIZE, 511);
                    default:  a = $urandom_range(FRAME_BYTES, 511);
                endcase
                queue_cmd(op, a, $urandom_range(0, 255));
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Load every store entry first so no render reads an unwritten one
        for (int i = 0; i < GAMMA_SIZE; i++)
            queue_cmd(OP_GAMMA, i, $urandom_range(0, 255));
        for (int i = 0; i < LED_COUNT; i++)
            queue_cmd(OP_MAP, i, $urandom_range(0, 255));
        for (int i = 0; i < FRAME_BYTES; i++)
            queue_cmd(OP_FRAME, i, $urandom_range(0, 255));

        // Directed: field extremes, map data with bit 7 set, dropped writes
        queue_cmd(OP_FRAME, 0, 8'hFF);
        queue_cmd(OP_FRAME, FRAME_BYTES - 1, 8'h00);
        queue_cmd(OP_MAP, 0, 8'hFF);
        queue_cmd(OP_MAP, LED_COUNT - 1, 8'h00);
        queue_cmd(OP_GAMMA, GAMMA_SIZE - 1, 8'hA5);
        queue_cmd(OP_GAMMA, 0, 8'h5A);
        queue_cmd(OP_FRAME, FRAME_BYTES, 8'h11);
        queue_cmd(OP_MAP, LED_COUNT, 8'h22);
        queue_cmd(OP_GAMMA, GAMMA_SIZE, 8'h33);
        queue_cmd(OP_FRAME, 511, 8'h44);
        // renders at both ends of the chain, each channel of the first LED; past the end gives nothing
        queue_cmd(OP_RENDER, 0, 8'h00);
        queue_cmd(OP_RENDER, 1, 8'hFF);
        queue_cmd(OP_RENDER, 2, 8'h00);
        queue_cmd(OP_RENDER, FRAME_BYTES - 2, 8'h00);
        queue_cmd(OP_RENDER, FRAME_BYTES - 1, 8'h00);
        queue_cmd(OP_RENDER, FRAME_BYTES, 8'h00);
        queue_cmd(OP_RENDER, 511, 8'h00);
        random_cmds(PHASE_BEATS);

        // Boost on at a clamped-range dim: one weak byte boosted, one saturating
        apply_setting(settings[0]);
        queue_cmd(OP_MAP, 14, 5);
        queue_cmd(OP_FRAME, 16, 10);
        queue_cmd(OP_FRAME, 15, 255);
        queue_cmd(OP_RENDER, 42, 0);
        queue_cmd(OP_RENDER, 43, 0);
        queue_cmd(OP_RENDER, 45, 0);
        queue_cmd(OP_RENDER, 77 * 3 + 2, 0);
        queue_cmd(OP_RENDER, 78 * 3, 0);
        queue_cmd(OP_RENDER, 81 * 3 + 1, 0);
        random_cmds(PHASE_BEATS);

        for (int s = 1; s < 9; s++)
        begin
            apply_setting(settings[s]);
            random_cmds(PHASE_BEATS);
        end

        wait_idle();
        repeat (16) @(posedge clk);
        $display("Covered %0d command beats across %0d register settings.",
                 beats_taken, settings_done);
        $display("Compared %0d chain bytes, %0d of them on boosted weak LEDs.",
                 bytes_checked, boosted_bytes);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Backstop: several times the slowest legal run
    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
